>>> design/mct_pkg.sv
package mct_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_FIND  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_ERASE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RES_NONE  = 3'd0,
    RES_WRITE = 3'd1,
    RES_READ  = 3'd2,
    RES_FIND  = 3'd3,
    RES_ERASE = 3'd4
  } res_sel_e;

  localparam int unsigned CodeW  = 32;
  localparam int unsigned IndexW = 11;
  localparam int unsigned FoundW = 10;

  localparam logic [CodeW-1:0] ErasedWord = 32'hFFFF_FFFF;

  // controller to datapath
  typedef struct packed {
    logic     load_item;
    logic     cnt_clr;
    logic     clear_wr;
    logic     store_wr;
    logic     rd_idx;
    logic     scan;
    res_sel_e res_sel;
    logic     out_load;
  } mct_ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e in_cmd;
    logic clear_last;
    logic scan_end;
    logic out_free;
  } mct_sts_t;

endpackage

>>> design/mct_in_if.sv
interface mct_in_if
  import mct_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [IndexW-1:0] index;
  logic [CodeW-1:0]  code;
  logic [CodeW-1:0]  match_mask;

  modport source (output valid, output cmd, output index, output code, output match_mask,
                  input ready);
  modport sink (input valid, input cmd, input index, input code, input match_mask,
                output ready);
endinterface

>>> design/mct_out_if.sv
interface mct_out_if
  import mct_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              status;
  logic [FoundW-1:0] found_index;
  logic [CodeW-1:0]  read_data;

  modport source (output valid, output status, output found_index, output read_data,
                  input ready);
  modport sink (input valid, input status, input found_index, input read_data,
                output ready);
endinterface

>>> design/mct_ctrl.sv
module mct_ctrl
  import mct_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mct_sts_t sts_i,
  output mct_ctl_t ctl_o
);

  typedef enum logic [7:0] {
    S_INIT  = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_WRITE = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_RDATA = 8'b0001_0000,
    S_FIND  = 8'b0010_0000,
    S_ERASE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.res_sel = RES_NONE;
    unique case (state_q)
      S_INIT: begin
        ctl_o.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          ctl_o.load_item = 1'b1;
          ctl_o.cnt_clr   = 1'b1;
          unique case (sts_i.in_cmd)
            CMD_WRITE: state_d = S_WRITE;
            CMD_FIND:  state_d = S_FIND;
            CMD_READ:  state_d = S_READ;
            CMD_ERASE: state_d = S_ERASE;
            default:   state_d = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        ctl_o.store_wr = 1'b1;
        ctl_o.res_sel  = RES_WRITE;
        state_d        = S_DONE;
      end
      S_READ: begin
        ctl_o.rd_idx = 1'b1;
        state_d      = S_RDATA;
      end
      S_RDATA: begin
        ctl_o.res_sel = RES_READ;
        state_d       = S_DONE;
      end
      S_FIND: begin
        ctl_o.scan = 1'b1;
        if (sts_i.scan_end) begin
          ctl_o.res_sel = RES_FIND;
          state_d       = S_DONE;
        end
      end
      S_ERASE: begin
        ctl_o.clear_wr = 1'b1;
        if (sts_i.clear_last) begin
          ctl_o.res_sel = RES_ERASE;
          state_d       = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != S_IDLE)
    else $error("controller stayed idle after an input transfer");

  a_find_exits_to_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |=> (state_q == S_FIND) || (state_q == S_DONE))
    else $error("find scan left to a wrong state");

endmodule

>>> design/mct_datapath.sv
module mct_datapath
  import mct_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        in_cmd_i,
  input  logic [IndexW-1:0] in_index_i,
  input  logic [CodeW-1:0]  in_code_i,
  input  logic [CodeW-1:0]  in_mask_i,
  input  mct_ctl_t          ctl_i,
  output mct_sts_t          sts_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_status_o,
  output logic [FoundW-1:0] out_found_o,
  output logic [CodeW-1:0]  out_data_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  logic [CodeW-1:0] mem [ENTRIES];

  logic [IndexW-1:0] item_index_q;
  logic [CodeW-1:0]  item_code_q;
  logic [CodeW-1:0]  item_mask_q;

  logic [CW-1:0]    cnt_q;
  logic [AW-1:0]    rd_addr_q;
  logic             rd_vld_q;
  logic [CodeW-1:0] rdata_q;

  logic              res_status_q;
  logic [FoundW-1:0] res_found_q;
  logic [CodeW-1:0]  res_data_q;

  logic              out_valid_q;
  logic              out_status_q;
  logic [FoundW-1:0] out_found_q;
  logic [CodeW-1:0]  out_data_q;

  logic [31:0]      idx_ext;
  logic [31:0]      rd_addr_ext;
  logic             in_range;
  logic [AW-1:0]    item_addr;
  logic             scan_issue;
  logic             scan_hit;
  logic             scan_last;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [CodeW-1:0] wdata;
  logic             re;
  logic [AW-1:0]    raddr;

  assign idx_ext     = {{(32 - IndexW){1'b0}}, item_index_q};
  assign in_range    = idx_ext < 32'(ENTRIES);
  assign item_addr   = idx_ext[AW-1:0];
  assign rd_addr_ext = 32'(rd_addr_q);

  assign scan_issue = ctl_i.scan && (cnt_q < CW'(ENTRIES));
  assign scan_hit   = rd_vld_q && ((rdata_q & item_mask_q) == (item_code_q & item_mask_q));
  assign scan_last  = rd_vld_q && (rd_addr_q == AW'(ENTRIES - 1));

  always_comb begin
    we    = 1'b0;
    waddr = item_addr;
    wdata = item_code_q;
    if (ctl_i.clear_wr) begin
      we    = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = ErasedWord;
    end else if (ctl_i.store_wr && in_range) begin
      we = 1'b1;
    end
  end

  assign re    = ctl_i.rd_idx || scan_issue;
  assign raddr = ctl_i.rd_idx ? item_addr : cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      item_index_q <= in_index_i;
      item_code_q  <= in_code_i;
      item_mask_q  <= in_mask_i;
    end
    if (scan_issue) rd_addr_q <= cnt_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= scan_issue;
      if (ctl_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (ctl_i.clear_wr || scan_issue) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  // result staging, held until the output register is free
  always_ff @(posedge clk_i) begin
    case (ctl_i.res_sel)
      RES_WRITE: begin
        res_status_q <= !in_range;
        res_found_q  <= '0;
        res_data_q   <= '0;
      end
      RES_READ: begin
        res_status_q <= !in_range;
        res_found_q  <= '0;
        res_data_q   <= in_range ? rdata_q : ErasedWord;
      end
      RES_FIND: begin
        res_status_q <= !scan_hit;
        res_found_q  <= scan_hit ? rd_addr_ext[FoundW-1:0] : '0;
        res_data_q   <= '0;
      end
      RES_ERASE: begin
        res_status_q <= 1'b0;
        res_found_q  <= '0;
        res_data_q   <= '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_found_q  <= res_found_q;
      out_data_q   <= res_data_q;
    end
  end

  assign sts_o.in_cmd     = cmd_e'(in_cmd_i);
  assign sts_o.clear_last = (cnt_q == CW'(ENTRIES - 1));
  assign sts_o.scan_end   = scan_hit || scan_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_found_o  = out_found_q;
  assign out_data_o   = out_data_q;

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_single_writer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_i.clear_wr && ctl_i.store_wr))
    else $error("clear and store write in the same cycle");

  a_oob_read_erased: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.res_sel == RES_READ && !in_range) |=> (res_data_q == ErasedWord && res_status_q))
    else $error("out of range read did not return the erased word");

endmodule

>>> design/masked_code_table.sv
// Table of ENTRIES 32-bit codes with write, masked find, read and erase commands; each
// input transfer gives exactly one result transfer. After reset the block runs a clearing
// pass that writes all ones into every entry and accepts no input until it ends. Masked find
// reads one entry per cycle through the single read port of the table memory and stops at
// the first hit, or after the last entry on a miss. Erase rewrites the table one entry per
// cycle through the write port. The next input is taken while a finished result still waits
// in the output register.
module masked_code_table
  import mct_pkg::*;
#(
  parameter int unsigned ENTRIES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  mct_in_if.sink    in_i,
  mct_out_if.source out_o
);

  mct_ctl_t ctl;
  mct_sts_t sts;

  mct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  mct_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_cmd_i     (in_i.cmd),
    .in_index_i   (in_i.index),
    .in_code_i    (in_i.code),
    .in_mask_i    (in_i.match_mask),
    .ctl_i        (ctl),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_found_o  (out_o.found_index),
    .out_data_o   (out_o.read_data)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import mct_pkg::*;

  localparam int unsigned ENTRIES   = 1024;
  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam int unsigned SHOWN_MAX = 10;
  localparam int unsigned IDLE_PCT  = 23;
  localparam int unsigned HOT_SPAN  = 64;

  localparam logic [CodeW-1:0]  ALL_ONES  = 32'hFFFF_FFFF;
  localparam logic [CodeW-1:0]  LOW_HALF  = 32'h0000_FFFF;
  localparam logic [CodeW-1:0]  HIGH_HALF = 32'hFFFF_0000;
  localparam logic [CodeW-1:0]  LOW_BYTE  = 32'h0000_00FF;
  localparam logic [IndexW-1:0] LAST_IDX  = IndexW'(ENTRIES - 1);
  localparam logic [IndexW-1:0] FIRST_OUT = IndexW'(ENTRIES);
  localparam logic [IndexW-1:0] TOP_IDX   = {IndexW{1'b1}};

  typedef struct packed {
    logic              status;
    logic [FoundW-1:0] found_index;
    logic [CodeW-1:0]  read_data;
  } table_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  always #1 clk_i = ~clk_i;

  mct_in_if  cmd_if ();
  mct_out_if res_if ();

  masked_code_table #(
    .ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_if),
    .out_o (res_if)
  );

  logic [CodeW-1:0] shadow_table [ENTRIES];
  table_res_t       pending_results [$];
  int unsigned      mismatch_count = 0;
  bit               no_idle = 1'b0;

  function automatic void erase_table();
    for (int i = 0; i < ENTRIES; i++) begin
      shadow_table[i] = ALL_ONES;
    end
  endfunction

  // applies one command to the shadow table and returns the result it should give
  function automatic table_res_t apply_command(cmd_e op, logic [IndexW-1:0] idx,
                                               logic [CodeW-1:0] code,
                                               logic [CodeW-1:0] mask);
    table_res_t res;
    logic       in_range;
    logic       hit;
    res      = '0;
    in_range = (idx < ENTRIES);
    hit      = 1'b0;
    case (op)
      CMD_WRITE: begin
        if (in_range) begin
          shadow_table[idx] = code;
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_FIND: begin
        res.status = 1'b1;
        for (int i = 0; i < ENTRIES && !hit; i++) begin
          if ((shadow_table[i] & mask) == (code & mask)) begin
            hit             = 1'b1;
            res.status      = 1'b0;
            res.found_index = FoundW'(i);
          end
        end
      end
      CMD_READ: begin
        if (in_range) begin
          res.read_data = shadow_table[idx];
        end else begin
          res.status    = 1'b1;
          res.read_data = ALL_ONES;
        end
      end
      default: begin
        erase_table();
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_MAX) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  // result check first, then prediction for an input transfer at the same edge
  always @(posedge clk_i) begin : check_results
    table_res_t want;
    table_res_t got;
    if (rst_ni) begin
      if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
        got = '{res_if.status, res_if.found_index, res_if.read_data};
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with none waiting: status %0d found_index %0d read_data %h",
                                    got.status, got.found_index, got.read_data));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            report_mismatch($sformatf(
              "result mismatch: expected status %0d found_index %0d read_data %h, got status %0d found_index %0d read_data %h",
              want.status, want.found_index, want.read_data,
              got.status, got.found_index, got.read_data));
          end
        end
      end
      if (cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) begin
        pending_results.push_back(apply_command(cmd_e'(cmd_if.cmd), cmd_if.index,
                                                cmd_if.code, cmd_if.match_mask));
      end
    end
  end

  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      res_if.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // called at a falling edge, returns at a falling edge after the transfer and any gap
  task automatic send_command(cmd_e op, logic [IndexW-1:0] idx, logic [CodeW-1:0] code,
                              logic [CodeW-1:0] mask);
    cmd_if.valid      = 1'b1;
    cmd_if.cmd        = op;
    cmd_if.index      = idx;
    cmd_if.code       = code;
    cmd_if.match_mask = mask;
    do begin
      @(posedge clk_i);
    end while (cmd_if.ready !== 1'b1);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
  endtask

  function automatic logic [IndexW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return IndexW'($urandom_range(HOT_SPAN - 1));
    if (r < 90) return IndexW'($urandom_range(ENTRIES - 1));
    return IndexW'($urandom);
  endfunction

  function automatic logic [CodeW-1:0] pick_mask();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return ALL_ONES;
    if (r < 75) return $urandom;
    if (r < 85) return LOW_BYTE;
    if (r < 95) return HIGH_HALF;
    return '0;
  endfunction

  task automatic send_random_command();
    int unsigned      r;
    logic [CodeW-1:0] code;
    r = $urandom_range(99);
    if (r < 36) begin
      // some writes copy a stored code so finds see duplicates
      code = ($urandom_range(3) == 0) ? shadow_table[$urandom_range(HOT_SPAN - 1)] : $urandom;
      send_command(CMD_WRITE, pick_index(), code, $urandom);
    end else if (r < 64) begin
      send_command(CMD_READ, pick_index(), $urandom, $urandom);
    end else if (r < 97) begin
      // mostly look for a code that is stored, so the scan stops early
      code = ($urandom_range(9) < 7) ? shadow_table[$urandom_range(ENTRIES - 1)] : $urandom;
      if ($urandom_range(1) == 0) begin
        code = shadow_table[$urandom_range(HOT_SPAN - 1)];
      end
      send_command(CMD_FIND, IndexW'($urandom), code, pick_mask());
    end else begin
      send_command(CMD_ERASE, IndexW'($urandom), $urandom, $urandom);
    end
  endtask

  task automatic test_directed_cases();
    send_command(CMD_READ,  '0,        '0,             '0);
    send_command(CMD_READ,  LAST_IDX,  '0,             '0);
    send_command(CMD_READ,  FIRST_OUT, '0,             ALL_ONES);
    send_command(CMD_READ,  TOP_IDX,   ALL_ONES,       '0);
    send_command(CMD_WRITE, '0,        '0,             ALL_ONES);
    send_command(CMD_WRITE, LAST_IDX,  32'h1234_5678,  '0);
    send_command(CMD_WRITE, FIRST_OUT, 32'hA5A5_A5A5,  '0);
    send_command(CMD_WRITE, TOP_IDX,   32'h5A5A_5A5A,  ALL_ONES);
    send_command(CMD_WRITE, 11'd5,     32'h1234_5678,  '0);
    // duplicate code: the lower index wins
    send_command(CMD_FIND,  TOP_IDX,   32'h1234_5678,  ALL_ONES);
    // zero mask matches every entry
    send_command(CMD_FIND,  '0,        32'hDEAD_BEEF,  '0);
    send_command(CMD_FIND,  '0,        32'h8765_4321,  ALL_ONES);
    send_command(CMD_FIND,  '0,        ALL_ONES,       ALL_ONES);
    send_command(CMD_FIND,  '0,        32'hCAFE_5678,  LOW_HALF);
    send_command(CMD_READ,  '0,        '0,             '0);
    send_command(CMD_READ,  11'd5,     '0,             '0);
    send_command(CMD_READ,  LAST_IDX,  '0,             '0);
    send_command(CMD_ERASE, '0,        '0,             '0);
    send_command(CMD_READ,  LAST_IDX,  '0,             '0);
    send_command(CMD_FIND,  '0,        '0,             32'h0000_0001);
    send_command(CMD_WRITE, LAST_IDX,  '0,             '0);
    // hit only at the last entry
    send_command(CMD_FIND,  '0,        '0,             ALL_ONES);
    send_command(CMD_ERASE, TOP_IDX,   ALL_ONES,       ALL_ONES);
    send_command(CMD_ERASE, '0,        '0,             '0);
  endtask

  task automatic test_random_commands(int unsigned count);
    repeat (count) send_random_command();
  endtask

  task automatic test_steady_stream(int unsigned count);
    no_idle = 1'b1;
    repeat (count) send_random_command();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni               = 1'b0;
    cmd_if.valid         = 1'b0;
    cmd_if.cmd           = CMD_WRITE;
    cmd_if.index         = '0;
    cmd_if.code          = '0;
    cmd_if.match_mask    = '0;
    erase_table();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_random_commands(400);
    test_steady_stream(160);
    cmd_if.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 16) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
